// ----- hdl/three_level_page_table_walker_top_assert.svh -----
// Assertion macros for the page table walker.
`ifndef THREE_LEVEL_PAGE_TABLE_WALKER_TOP_ASSERT_SVH
`define THREE_LEVEL_PAGE_TABLE_WALKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TLPTW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TLPTW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tlptw_pkg.sv -----
package tlptw_pkg;

   localparam int ADDR_W         = 64;
   localparam int PAGE_SHIFT     = 12;
   localparam int PPN_BITS       = 44;
   localparam int PPN_LSB        = 10;
   localparam int INDEX_BITS     = 9;
   localparam int ENTRY_SHIFT    = 3;
   localparam int LEVEL_W        = 2;
   localparam int LEVELS_DEFAULT = 3;
   localparam logic [2:0] TYPE_MASK = 3'h7;

   typedef enum logic {
      REQ_TRANSLATE = 1'b0,
      REQ_ENTRY     = 1'b1
   } req_kind_type;

   typedef enum logic {
      RESULT_READ = 1'b0,
      RESULT_DONE = 1'b1
   } result_kind_type;

   // lowest virtual address bit of the index for level lvl (0 = first)
   function automatic int level_shift(input int levels, input int lvl);
      return PAGE_SHIFT + INDEX_BITS * (levels - 1 - lvl);
   endfunction

endpackage

// ----- hdl/three_level_page_table_walker_top.sv -----
// Path: an accepted request word passes the input register, then decode
//   into the result register, which holds its response word.
// Throughput: one word per cycle; req_stall rises only while the result
//   register is full and rsp_stall is high.
// Reset (synchronous): clears valids, the walk state and the root page number.
module three_level_page_table_walker_top
   import tlptw_pkg::*;
#(
   parameter int LEVELS = LEVELS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [PPN_BITS-1:0]  csr_root_page_number,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [ADDR_W-1:0]    req_virt_addr,
   input  logic [ADDR_W-1:0]    req_entry_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_result_kind,
   output logic [ADDR_W-1:0]    rsp_address,
   output logic                 rsp_success
);

   `include "three_level_page_table_walker_top_assert.svh"

   localparam int VA_W     = PAGE_SHIFT + INDEX_BITS * LEVELS;
   localparam int ADDR_PAD = ADDR_W - PPN_BITS - INDEX_BITS - ENTRY_SHIFT;
   localparam int PA_PAD   = ADDR_W - PPN_BITS - PAGE_SHIFT;

   logic [PPN_BITS-1:0]  root_ff;
   logic                 in_valid_ff;
   logic                 in_type_ff;
   logic [ADDR_W-1:0]    in_va_ff;
   logic [ADDR_W-1:0]    in_entry_ff;
   logic                 out_valid_ff;
   logic                 out_kind_ff;
   logic [ADDR_W-1:0]    out_addr_ff;
   logic                 out_ok_ff;
   logic                 walk_active_ff;
   logic [LEVEL_W-1:0]   walk_level_ff;
   logic [VA_W-1:0]      held_vaddr_ff;

   logic                 out_kind_in;
   logic [ADDR_W-1:0]    out_addr_in;
   logic                 out_ok_in;
   logic                 walk_active_in;
   logic [LEVEL_W-1:0]   walk_level_in;
   logic [VA_W-1:0]      held_vaddr_in;

   logic                 advance;
   logic                 process;
   logic [LEVEL_W:0]     next_level;
   logic [INDEX_BITS-1:0] first_idx;
   logic [INDEX_BITS-1:0] next_idx;
   logic [ADDR_W-1:0]    off_mask;
   logic [PPN_BITS-1:0]  entry_ppn;
   logic [ADDR_W-1:0]    leaf_pa;

   assign csr_ready = 1'b1;
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign process   = in_valid_ff && advance;

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_address     = out_addr_ff;
   assign rsp_success     = out_ok_ff;

   // per-level index and offset selection
   always_comb begin
      next_level = {1'b0, walk_level_ff} + 1'b1;
      first_idx  = in_va_ff[level_shift(LEVELS, 0) +: INDEX_BITS];
      next_idx   = '0;
      off_mask   = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (next_level == (LEVEL_W+1)'(l)) begin
            next_idx = held_vaddr_ff[level_shift(LEVELS, l) +: INDEX_BITS];
         end
         if (walk_level_ff == LEVEL_W'(l)) begin
            off_mask = (ADDR_W'(1) << level_shift(LEVELS, l)) - ADDR_W'(1);
         end
      end
      entry_ppn = in_entry_ff[PPN_LSB +: PPN_BITS];
      leaf_pa   = ({{PA_PAD{1'b0}}, entry_ppn, {PAGE_SHIFT{1'b0}}} & ~off_mask) |
                  (ADDR_W'(held_vaddr_ff) & off_mask);
   end

   always_comb begin
      out_kind_in    = RESULT_DONE;
      out_addr_in    = '0;
      out_ok_in      = 1'b0;
      walk_active_in = walk_active_ff;
      walk_level_in  = walk_level_ff;
      held_vaddr_in  = held_vaddr_ff;
      if (in_type_ff == REQ_TRANSLATE) begin
         if (walk_active_ff) begin
            out_ok_in = 1'b0;
         end else if (root_ff == '0) begin
            out_addr_in = in_va_ff;
            out_ok_in   = 1'b1;
         end else begin
            held_vaddr_in  = in_va_ff[VA_W-1:0];
            walk_level_in  = '0;
            walk_active_in = 1'b1;
            out_kind_in    = RESULT_READ;
            out_addr_in    = {{ADDR_PAD{1'b0}}, root_ff, first_idx, {ENTRY_SHIFT{1'b0}}};
         end
      end else if (!walk_active_ff) begin
         out_ok_in = 1'b0;
      end else if (!in_entry_ff[0]) begin
         walk_active_in = 1'b0;
         walk_level_in  = '0;
      end else if ((in_entry_ff[3:1] & TYPE_MASK) != 3'b000) begin
         walk_active_in = 1'b0;
         walk_level_in  = '0;
         out_addr_in    = leaf_pa;
         out_ok_in      = 1'b1;
      end else if (next_level >= (LEVEL_W+1)'(LEVELS)) begin
         walk_active_in = 1'b0;
         walk_level_in  = '0;
      end else begin
         walk_level_in = next_level[LEVEL_W-1:0];
         out_kind_in   = RESULT_READ;
         out_addr_in   = {{ADDR_PAD{1'b0}}, entry_ppn, next_idx, {ENTRY_SHIFT{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff        <= '0;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         walk_active_ff <= 1'b0;
         walk_level_ff  <= '0;
         held_vaddr_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            root_ff <= csr_root_page_number;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (process) begin
            walk_active_ff <= walk_active_in;
            walk_level_ff  <= walk_level_in;
            held_vaddr_ff  <= held_vaddr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_type_ff  <= req_type;
         in_va_ff    <= req_virt_addr;
         in_entry_ff <= req_entry_data;
      end
      if (process) begin
         out_kind_ff <= out_kind_in;
         out_addr_ff <= out_addr_in;
         out_ok_ff   <= out_ok_in;
      end
   end

   `TLPTW_ASSERT_NOW(a_read_means_walk, clock, reset,
      out_valid_ff && (out_kind_ff == RESULT_READ), walk_active_ff,
      "read word shown without an active walk")
   `TLPTW_ASSERT_NOW(a_success_done, clock, reset,
      out_valid_ff && out_ok_ff, out_kind_ff == RESULT_DONE,
      "success flagged on a read word")
   `TLPTW_ASSERT_NOW(a_level_range, clock, reset,
      walk_active_ff, {1'b0, walk_level_ff} < (LEVEL_W+1)'(LEVELS),
      "walk level beyond last level")
   `TLPTW_ASSERT_NEXT(a_idle_level, clock, reset,
      process && !walk_active_in, walk_level_ff == '0,
      "walk level not cleared at walk end")

endmodule
